[hdl/sed_pkg.sv]
// ----------------------------------------------------------------------------
// String escape decoder package
// Shared word types and the queue entry type passed between the front and
// back parts of the decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

   // One character word of the literal text.
   typedef struct packed {
      logic [7:0] ch;
      logic       first_char;
      logic       last_char;
   } req_word_type;

   // One decoded result word.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_literal;
      logic       last_of_run;
   } rsp_word_type;

   // A burst of one to three result words caused by one character word.
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      last_idx;
      logic            eol;
      logic            bare;
   } burst_type;

   // Queue status seen by the front part.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[hdl/sed_front.sv]
// ----------------------------------------------------------------------------
// String escape decoder front part
// Accepts one character word per cycle while the queue is not full, tracks
// the escape and hex state and turns each word into a result burst for the queue.
// ----------------------------------------------------------------------------
module sed_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  sed_pkg::req_word_type     req_word,
   output logic                      req_stall,
   input  sed_pkg::queue_status_type q_status,
   output logic                      push,
   output sed_pkg::burst_type        push_burst
);
   import sed_pkg::*;

   // Decoding modes.
   typedef enum logic [3:0] {
      MODE_NORMAL  = 4'b0001,
      MODE_ESCAPE  = 4'b0010,
      MODE_HEXBYTE = 4'b0100,
      MODE_UNICODE = 4'b1000
   } mode_type;

   // Character codes.
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BTICK  = 8'h60;
   localparam logic [7:0] CH_QMARK  = 8'h3f;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6e;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_LOW_X  = 8'h78;
   localparam logic [7:0] CH_UP_X   = 8'h58;
   localparam logic [7:0] CH_DIG_0  = 8'h30;
   localparam logic [7:0] CH_DIG_9  = 8'h39;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_F   = 8'h46;

   // Control byte values.
   localparam logic [7:0] BYTE_BEL = 8'h07;
   localparam logic [7:0] BYTE_BS  = 8'h08;
   localparam logic [7:0] BYTE_FF  = 8'h0c;
   localparam logic [7:0] BYTE_LF  = 8'h0a;
   localparam logic [7:0] BYTE_CR  = 8'h0d;
   localparam logic [7:0] BYTE_TAB = 8'h09;

   localparam logic [2:0] HEXBYTE_DIGITS = 3'd2;
   localparam logic [2:0] UNICODE_DIGITS = 3'd4;

   // A group of bytes with its count.
   typedef struct packed {
      logic [1:0]      n;
      logic [2:0][7:0] b;
   } bytes_type;

   mode_type    mode_ff, mode_in;
   logic [2:0]  digits_ff, digits_in;
   logic [15:0] accum_ff, accum_in;
   logic        stopped_ff, stopped_in;
   logic        prefix_ff, prefix_in;
   logic        second_ff, second_in;

   logic        accept;
   logic        is_hex;
   logic [3:0]  hex_val;
   logic [15:0] accum_step;
   bytes_type   emit;
   logic        closing;

   // Encode the collected hex value as one byte or as UTF-8.
   function automatic bytes_type flush_hex(input mode_type mode, input logic [15:0] v);
      bytes_type r;
      r = '0;
      if (mode == MODE_HEXBYTE) begin
         r.n    = 2'd1;
         r.b[0] = v[7:0];
      end else if (mode == MODE_UNICODE) begin
         if (v <= 16'h007f) begin
            r.n    = 2'd1;
            r.b[0] = v[7:0];
         end else if (v <= 16'h07ff) begin
            r.n    = 2'd2;
            r.b[0] = 8'hc0 | {3'b000, v[10:6]};
            r.b[1] = 8'h80 | {2'b00, v[5:0]};
         end else begin
            r.n    = 2'd3;
            r.b[0] = 8'he0 | {4'h0, v[15:12]};
            r.b[1] = 8'h80 | {2'b00, v[11:6]};
            r.b[2] = 8'h80 | {2'b00, v[5:0]};
         end
      end
      return r;
   endfunction

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // Hex digit recognition.
   always_comb begin
      is_hex  = 1'b0;
      hex_val = 4'h0;
      if (req_word.ch >= CH_DIG_0 && req_word.ch <= CH_DIG_9) begin
         is_hex  = 1'b1;
         hex_val = 4'(req_word.ch - CH_DIG_0);
      end else if (req_word.ch >= CH_LOW_A && req_word.ch <= CH_LOW_F) begin
         is_hex  = 1'b1;
         hex_val = 4'(req_word.ch - CH_LOW_A + 8'd10);
      end else if (req_word.ch >= CH_UP_A && req_word.ch <= CH_UP_F) begin
         is_hex  = 1'b1;
         hex_val = 4'(req_word.ch - CH_UP_A + 8'd10);
      end
      accum_step = (stopped_ff || !is_hex) ? accum_ff : {accum_ff[11:0], hex_val};
   end

   // Next state and the bytes caused by this word.
   always_comb begin
      mode_in    = mode_ff;
      digits_in  = digits_ff;
      accum_in   = accum_ff;
      stopped_in = stopped_ff;
      prefix_in  = prefix_ff;
      second_in  = second_ff;
      emit       = '0;
      closing    = 1'b0;
      if (req_word.first_char) begin
         mode_in    = MODE_NORMAL;
         digits_in  = '0;
         accum_in   = '0;
         stopped_in = 1'b0;
         prefix_in  = (req_word.ch == CH_LOW_B);
         second_in  = !req_word.last_char;
         closing    = req_word.last_char;
      end else if (req_word.last_char) begin
         // A pending hex group is flushed with the digits read so far.
         emit       = flush_hex(mode_ff, accum_ff);
         mode_in    = MODE_NORMAL;
         digits_in  = '0;
         accum_in   = '0;
         stopped_in = 1'b0;
         second_in  = 1'b0;
         closing    = 1'b1;
      end else if (second_ff && prefix_ff) begin
         second_in = 1'b0;
      end else begin
         second_in = 1'b0;
         case (mode_ff)
            MODE_NORMAL: begin
               if (req_word.ch == CH_BSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  emit.n    = 2'd1;
                  emit.b[0] = req_word.ch;
               end
            end
            MODE_ESCAPE: begin
               mode_in = MODE_NORMAL;
               emit.n  = 2'd1;
               case (req_word.ch)
                  CH_LOW_A: emit.b[0] = BYTE_BEL;
                  CH_LOW_B: emit.b[0] = BYTE_BS;
                  CH_LOW_F: emit.b[0] = BYTE_FF;
                  CH_LOW_N: emit.b[0] = BYTE_LF;
                  CH_LOW_R: emit.b[0] = BYTE_CR;
                  CH_LOW_T: emit.b[0] = BYTE_TAB;
                  CH_LOW_E, CH_QMARK: begin
                     emit.n    = 2'd2;
                     emit.b[0] = CH_BSLASH;
                     emit.b[1] = req_word.ch;
                  end
                  CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_BTICK: begin
                     emit.b[0] = req_word.ch;
                  end
                  CH_LOW_X, CH_UP_X: begin
                     emit.n     = 2'd0;
                     mode_in    = MODE_HEXBYTE;
                     digits_in  = HEXBYTE_DIGITS;
                     accum_in   = '0;
                     stopped_in = 1'b0;
                  end
                  CH_LOW_U: begin
                     emit.n     = 2'd0;
                     mode_in    = MODE_UNICODE;
                     digits_in  = UNICODE_DIGITS;
                     accum_in   = '0;
                     stopped_in = 1'b0;
                  end
                  default: emit.n = 2'd0;
               endcase
            end
            MODE_HEXBYTE, MODE_UNICODE: begin
               // Digits are taken until the first non-hex character.
               accum_in   = accum_step;
               stopped_in = stopped_ff || !is_hex;
               if (digits_ff <= 3'd1) begin
                  emit       = flush_hex(mode_ff, accum_step);
                  mode_in    = MODE_NORMAL;
                  digits_in  = '0;
                  accum_in   = '0;
                  stopped_in = 1'b0;
               end else begin
                  digits_in = digits_ff - 3'd1;
               end
            end
            default: mode_in = MODE_NORMAL;
         endcase
      end
   end

   // Burst for the queue; a closing word with no data gives a bare end marker.
   always_comb begin
      push_burst.data     = emit.b;
      push_burst.last_idx = emit.n - 2'd1;
      push_burst.eol      = closing;
      push_burst.bare     = 1'b0;
      push                = accept && (emit.n != 2'd0 || closing);
      if (closing && emit.n == 2'd0) begin
         push_burst.data     = '0;
         push_burst.last_idx = 2'd0;
         push_burst.bare     = 1'b1;
      end
   end

   // Decoder state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NORMAL;
         digits_ff  <= '0;
         accum_ff   <= '0;
         stopped_ff <= 1'b0;
         prefix_ff  <= 1'b0;
         second_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         digits_ff  <= digits_in;
         accum_ff   <= accum_in;
         stopped_ff <= stopped_in;
         prefix_ff  <= prefix_in;
         second_ff  <= second_in;
      end
   end

endmodule

[hdl/sed_queue.sv]
// ----------------------------------------------------------------------------
// String escape decoder burst queue
// A short register queue of result bursts between the front and back parts.
// ----------------------------------------------------------------------------
module sed_queue #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sed_pkg::burst_type        push_burst,
   input  logic                      pop,
   output sed_pkg::burst_type        head,
   output sed_pkg::queue_status_type status
);
   import sed_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

   burst_type     slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_burst;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[hdl/sed_back.sv]
// ----------------------------------------------------------------------------
// String escape decoder back part
// Takes the burst at the head of the queue and delivers its bytes one result
// word per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module sed_back (
   input  logic                      clock,
   input  logic                      reset,
   input  sed_pkg::burst_type        head,
   input  sed_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   output sed_pkg::rsp_word_type     rsp_word,
   input  logic                      rsp_stall
);
   import sed_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       at_last;
   logic       accept;

   assign rsp_valid = !q_status.empty;
   assign at_last   = (idx_ff == head.last_idx);
   assign accept    = rsp_valid && !rsp_stall;
   assign pop       = accept && at_last;

   // Result word for the current byte of the burst.
   always_comb begin
      rsp_word.out_byte       = head.bare ? 8'h00 : head.data[idx_ff];
      rsp_word.byte_valid     = !head.bare;
      rsp_word.end_of_literal = head.eol && at_last;
      rsp_word.last_of_run    = at_last;
   end

   // Byte position within the burst.
   always_comb begin
      idx_in = idx_ff;
      if (accept) begin
         idx_in = at_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

[hdl/string_escape_decoder.sv]
// ----------------------------------------------------------------------------
// String escape decoder
// Decodes a quoted string literal arriving one character word at a time.
// ----------------------------------------------------------------------------
// The block takes one character word per cycle as long as its burst queue has
// room, and delivers one result word per cycle while the result side does not
// stall. A character word causes zero to three result words; the decoded
// bytes of one word are registered in the burst queue before they reach the
// result port. The single-byte result port sets the sustained rate, and the
// QUEUE_DEPTH-entry queue absorbs the bursts of escapes and UTF-8 sequences
// in between.
module string_escape_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  sed_pkg::req_word_type req_word,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output sed_pkg::rsp_word_type rsp_word,
   input  logic                  rsp_stall
);
   import sed_pkg::*;

   queue_status_type q_status;
   burst_type        push_burst;
   burst_type        head;
   logic             push;
   logic             pop;

   // Front part: classifies characters and builds result bursts.
   sed_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_word   (req_word),
      .req_stall  (req_stall),
      .q_status   (q_status),
      .push       (push),
      .push_burst (push_burst)
   );

   // Queue of bursts between the two parts.
   sed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_burst (push_burst),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // Back part: serialises each burst into result words.
   sed_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_stall (rsp_stall)
   );

`ifndef ASSERT_OFF
   // The end of a literal is always the last word of its run.
   a_eol_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.end_of_literal |-> rsp_word.last_of_run)
      else $error("end of literal word is not last of its run");

   // A bare end marker carries a zero byte and closes both the run and literal.
   a_bare_marker : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.byte_valid |->
         rsp_word.end_of_literal && rsp_word.last_of_run && rsp_word.out_byte == 8'h00)
      else $error("malformed bare end marker");

   // Nothing is offered on the result side straight after reset.
   a_reset_empty : assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // A burst is only queued for an accepted character word.
   a_push_on_accept : assert property (@(posedge clock) disable iff (reset)
      push |-> req_valid && !req_stall)
      else $error("burst queued without an accepted word");
`endif

endmodule
